// ===== design/yuv_to_rgbx_rotating_writer_core_assert.svh =====
// Assertion macros shared by the YUV to RGBX writer modules.
`ifndef YUV_TO_RGBX_ROTATING_WRITER_CORE_ASSERT_SVH
`define YUV_TO_RGBX_ROTATING_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define YTR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define YTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ytr_pkg.sv =====
// Types, constants and helpers of the YUV to RGBX rotating writer.
package ytr_pkg;

  localparam int unsigned IDX_W  = 24;
  localparam int unsigned REG_W  = 13;
  localparam int unsigned PROD_W = 22;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_mode_e;

  typedef enum logic [1:0] {
    REG_ROTATION = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2,
    REG_STRIDE   = 2'd3
  } cfg_reg_e;

  localparam logic signed [12:0] C_Y  = 13'sd1192;
  localparam logic signed [12:0] C_RV = 13'sd1634;
  localparam logic signed [12:0] C_GV = 13'sd833;
  localparam logic signed [12:0] C_GU = 13'sd400;
  localparam logic signed [12:0] C_BU = 13'sd2066;
  localparam logic signed [PROD_W-1:0] CH_MAX = 22'sd262143;
  localparam logic [7:0] ALPHA = 8'hff;
  localparam logic [7:0] LUMA_OFS = 8'd16;
  localparam logic signed [8:0] CHROMA_OFS = 9'sd128;

  typedef struct packed {
    logic [7:0] luma_sample;
    logic [7:0] blue_diff_sample;
    logic [7:0] red_diff_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      pixel_rgbx;
    logic [IDX_W-1:0] dest_index;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    rot_mode_e        rotation_mode;
    logic [REG_W-1:0] frame_width;
    logic [REG_W-1:0] frame_height;
    logic [REG_W-1:0] dest_stride;
  } cfg_t;

  typedef struct packed {
    in_item_t         pix;
    logic [IDX_W-1:0] idx_mul;
    logic [IDX_W-1:0] idx_add;
    logic             last;
  } job_t;

  function automatic logic [7:0] clamp_ch(input logic signed [PROD_W-1:0] s);
    logic [7:0] r;
    if (s < 0) begin
      r = 8'd0;
    end else if (s > CH_MAX) begin
      r = 8'hff;
    end else begin
      r = s[17:10];
    end
    return r;
  endfunction

endpackage

// ===== design/ytr_front.sv =====
// Front end: position counters, frame end detection and rotation operand selection.
`include "yuv_to_rgbx_rotating_writer_core_assert.svh"

module ytr_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ytr_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ytr_pkg::in_item_t in_req_i,
  output logic             push_o,
  input  logic             push_ready_i,
  output ytr_pkg::job_t    job_o
);
  import ytr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned XW = DW + 1;

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic [DW-1:0] w_eff, h_eff;
  logic [IDX_W-1:0] x_ext, y_ext, rx, ry;
  logic accept, row_end, frame_end;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(cfg_i.frame_width) > MAX_DIM) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = DW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      h_eff = DW'(1);
    end else if (32'(cfg_i.frame_height) > MAX_DIM) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = DW'(cfg_i.frame_height);
    end
  end

  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;
  assign push_o     = accept;

  assign row_end   = (XW'(col_q) + XW'(1)) >= XW'(w_eff);
  assign frame_end = row_end && ((XW'(row_q) + XW'(1)) >= XW'(h_eff));

  assign x_ext = IDX_W'(col_q);
  assign y_ext = IDX_W'(row_q);
  assign rx    = IDX_W'(w_eff) - IDX_W'(1) - x_ext;
  assign ry    = IDX_W'(h_eff) - IDX_W'(1) - y_ext;

  always_comb begin
    job_o.pix  = in_req_i;
    job_o.last = frame_end;
    unique case (cfg_i.rotation_mode)
      ROT_0: begin
        job_o.idx_mul = y_ext;
        job_o.idx_add = x_ext;
      end
      ROT_90: begin
        job_o.idx_mul = x_ext;
        job_o.idx_add = ry;
      end
      ROT_180: begin
        job_o.idx_mul = ry;
        job_o.idx_add = rx;
      end
      ROT_270: begin
        job_o.idx_mul = rx;
        job_o.idx_add = ry;
      end
      default: begin
        job_o.idx_mul = y_ext;
        job_o.idx_add = x_ext;
      end
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `YTR_ASSERT_NEXT(a_frame_wrap, clk_i, rst_ni, accept && frame_end,
                   col_q == '0 && row_q == '0, "Counters did not wrap at frame end.")
  `YTR_ASSERT_NEXT(a_col_step, clk_i, rst_ni, accept && !row_end,
                   col_q == $past(col_q) + CW'(1), "Column did not advance.")
  `YTR_ASSERT_NEXT(a_hold, clk_i, rst_ni, !accept,
                   $stable(col_q) && $stable(row_q), "Counters moved without a request.")

endmodule

// ===== design/ytr_queue.sv =====
// Two-entry queue between the front end and the conversion back end.
`include "yuv_to_rgbx_rotating_writer_core_assert.svh"

module ytr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  ytr_pkg::job_t job_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output ytr_pkg::job_t job_o
);
  import ytr_pkg::*;

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign job_o        = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  `YTR_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, push_i, cnt_q != 2'd2,
                   "Request pushed into a full queue.")
  `YTR_ASSERT_SAME(a_no_underflow, clk_i, rst_ni, pop_i, cnt_q != 2'd0,
                   "Request popped from an empty queue.")
  `YTR_ASSERT_SAME(a_ptr_count, clk_i, rst_ni, cnt_q == 2'd0 || cnt_q == 2'd2,
                   wr_ptr_q == rd_ptr_q, "Queue pointers disagree with the count.")

endmodule

// ===== design/ytr_back.sv =====
// Back end: color conversion, index multiply-add and the output register.
module ytr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ytr_pkg::REG_W-1:0]     dest_stride_i,
  input  logic                          pop_valid_i,
  output logic                          pop_o,
  input  ytr_pkg::job_t                 job_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ytr_pkg::out_item_t            out_req_o
);
  import ytr_pkg::*;

  logic s1_valid_q, out_valid_q;
  logic adv1, adv2;

  logic        [7:0]        y_off;
  logic signed [8:0]        y_s, u_s, v_s;
  logic signed [PROD_W-1:0] y_term_q, rv_q, gv_q, gu_q, bu_q;
  logic [IDX_W-1:0]         idx_prod_q, idx_add_q;
  logic                     last_q;
  logic signed [PROD_W-1:0] r_sum, g_sum, b_sum;
  out_item_t                out_q;

  assign adv2  = !out_valid_q || out_ready_i;
  assign adv1  = !s1_valid_q || adv2;
  assign pop_o = pop_valid_i && adv1;

  assign y_off = (job_i.pix.luma_sample >= LUMA_OFS) ?
                 job_i.pix.luma_sample - LUMA_OFS : 8'd0;
  assign y_s   = $signed({1'b0, y_off});
  assign u_s   = $signed({1'b0, job_i.pix.blue_diff_sample}) - CHROMA_OFS;
  assign v_s   = $signed({1'b0, job_i.pix.red_diff_sample}) - CHROMA_OFS;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      y_term_q   <= PROD_W'(y_s) * PROD_W'(C_Y);
      rv_q       <= PROD_W'(v_s) * PROD_W'(C_RV);
      gv_q       <= PROD_W'(v_s) * PROD_W'(C_GV);
      gu_q       <= PROD_W'(u_s) * PROD_W'(C_GU);
      bu_q       <= PROD_W'(u_s) * PROD_W'(C_BU);
      idx_prod_q <= job_i.idx_mul * IDX_W'(dest_stride_i);
      idx_add_q  <= job_i.idx_add;
      last_q     <= job_i.last;
    end
  end

  assign r_sum = y_term_q + rv_q;
  assign g_sum = y_term_q - gv_q - gu_q;
  assign b_sum = y_term_q + bu_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && adv2) begin
      out_q.pixel_rgbx <= {ALPHA, clamp_ch(r_sum), clamp_ch(g_sum), clamp_ch(b_sum)};
      out_q.dest_index <= idx_prod_q + idx_add_q;
      out_q.frame_last <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= pop_o;
      end
      if (adv2) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== design/yuv_to_rgbx_rotating_writer_core.sv =====
// Top level of the YUV to RGBX converter with rotated destination indexing.
//
//   Channel   Direction  Handshake             Payload
//   in        request    in_valid_i/in_ready_o in_req_i (Y, U, V samples)
//   out       result     out_valid_o/out_ready_i out_req_o (RGBX, index, last)
//   cfg       write      cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// One pixel per clock is sustained while out_ready_i stays high. An accepted request is
// written into the queue and passes the multiply stage, then the sum and clamp stage, on
// to the output. The front end takes a request whenever the two-entry queue has room.
// Reset clears the counters, the queue and the pipeline valid bits and loads the
// default frame of 640 by 480 with no rotation.
module yuv_to_rgbx_rotating_writer_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ytr_pkg::in_item_t         in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ytr_pkg::out_item_t        out_req_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [ytr_pkg::REG_W-1:0] cfg_wdata_i
);
  import ytr_pkg::*;

  cfg_t cfg_q;
  logic push, push_ready, pop_valid, pop;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation_mode <= ROT_0;
      cfg_q.frame_width   <= REG_W'(640);
      cfg_q.frame_height  <= REG_W'(480);
      cfg_q.dest_stride   <= REG_W'(640);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROTATION: cfg_q.rotation_mode <= rot_mode_e'(cfg_wdata_i[1:0]);
        REG_WIDTH:    cfg_q.frame_width   <= cfg_wdata_i;
        REG_HEIGHT:   cfg_q.frame_height  <= cfg_wdata_i;
        REG_STRIDE:   cfg_q.dest_stride   <= cfg_wdata_i;
        default:      cfg_q               <= cfg_q;
      endcase
    end
  end

  ytr_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .push_o      (push),
    .push_ready_i(push_ready),
    .job_o       (job_in)
  );

  ytr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .job_i       (job_in),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .job_o       (job_out)
  );

  ytr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dest_stride_i(cfg_q.dest_stride),
    .pop_valid_i  (pop_valid),
    .pop_o        (pop),
    .job_i        (job_out),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_req_o    (out_req_o)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the YUV to RGBX converter with rotated destination indexing.
module tb;
  import ytr_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  in_item_t          in_req_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_req_o;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [REG_W-1:0]  cfg_wdata_i = '0;

  rot_mode_e         cur_rot = ROT_0;
  logic [REG_W-1:0]  cur_width = 13'd640;
  logic [REG_W-1:0]  cur_height = 13'd480;
  logic [REG_W-1:0]  cur_stride = 13'd640;
  logic [11:0]       col_pos = '0;
  logic [11:0]       row_pos = '0;

  out_item_t         pending_pixels[$];
  bit                gaps_on = 1'b1;
  bit                stalls_on = 1'b1;
  int                stall_left = 0;
  int                idle_cycles = 0;
  int                error_count = 0;
  int                pixels_sent = 0;
  int                pixels_checked = 0;
  int                setups_applied = 0;
  int                random_sent = 0;

  yuv_to_rgbx_rotating_writer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] active_dim(input logic [REG_W-1:0] d);
    if (d == 0) begin
      return 32'd1;
    end
    if (d > 4096) begin
      return 32'd4096;
    end
    return 32'(d);
  endfunction

  function automatic int saturate_channel(input int c);
    if (c < 0) begin
      return 0;
    end
    if (c > 262143) begin
      return 262143;
    end
    return c;
  endfunction

  function automatic logic [31:0] convert_pixel(input in_item_t p);
    int yy, uu, vv, r, g, b;
    yy = int'(p.luma_sample) - 16;
    uu = int'(p.blue_diff_sample) - 128;
    vv = int'(p.red_diff_sample) - 128;
    if (yy < 0) begin
      yy = 0;
    end
    r = saturate_channel(1192 * yy + 1634 * vv) >>> 10;
    g = saturate_channel(1192 * yy - 833 * vv - 400 * uu) >>> 10;
    b = saturate_channel(1192 * yy + 2066 * uu) >>> 10;
    return {8'hff, r[7:0], g[7:0], b[7:0]};
  endfunction

  task automatic predict_pixel(input in_item_t p);
    logic [31:0] w, h, s, x, y, rx, ry, idx;
    logic        row_end, frame_end;
    out_item_t   o;
    w = active_dim(cur_width);
    h = active_dim(cur_height);
    s = 32'(cur_stride);
    x = 32'(col_pos);
    y = 32'(row_pos);
    rx = w - 1 - x;
    ry = h - 1 - y;
    row_end = (x + 1) >= w;
    frame_end = row_end && ((y + 1) >= h);
    case (cur_rot)
      ROT_0:   idx = y * s + x;
      ROT_90:  idx = x * s + ry;
      ROT_180: idx = ry * s + rx;
      default: idx = rx * s + ry;
    endcase
    o.pixel_rgbx = convert_pixel(p);
    o.dest_index = idx[IDX_W-1:0];
    o.frame_last = frame_end;
    pending_pixels.push_back(o);
    if (row_end) begin
      col_pos = '0;
      row_pos = frame_end ? 12'd0 : y[11:0] + 12'd1;
    end else begin
      col_pos = x[11:0] + 12'd1;
    end
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic send_pixel(input in_item_t px);
    int gap;
    if (gaps_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(4, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_pixel(px);
    pixels_sent++;
  endtask

  task automatic hold_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_setup(input rot_mode_e rot, input logic [REG_W-1:0] w,
                             input logic [REG_W-1:0] h, input logic [REG_W-1:0] s);
    logic [REG_W-1:0] data [4];
    hold_input();
    wait_for_drain();
    data[0] = {11'($urandom_range(2047)), rot};
    data[1] = w;
    data[2] = h;
    data[3] = s;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_wdata_i <= data[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_rot = rot;
    cur_width = w;
    cur_height = h;
    cur_stride = s;
    setups_applied++;
  endtask

  function automatic logic [7:0] random_sample();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_dim();
    case ($urandom_range(9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'($urandom_range(8191, 4097));
      default: return 13'($urandom_range(8, 2));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_stride();
    case ($urandom_range(7))
      0: return 13'd0;
      1: return 13'd8191;
      2: return 13'($urandom_range(8191));
      default: return 13'($urandom_range(16, 1));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("result with nothing expected: %h", out_req_o));
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_req_o.pixel_rgbx !== want.pixel_rgbx) begin
          note_error($sformatf("pixel_rgbx expected %h got %h",
                               want.pixel_rgbx, out_req_o.pixel_rgbx));
        end
        if (out_req_o.dest_index !== want.dest_index) begin
          note_error($sformatf("dest_index expected %0d got %0d",
                               want.dest_index, out_req_o.dest_index));
        end
        if (out_req_o.frame_last !== want.frame_last) begin
          note_error($sformatf("frame_last expected %b got %b",
                               want.frame_last, out_req_o.frame_last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("yuv_to_rgbx_rotating_writer_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_reset_defaults();
    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
  endtask

  task automatic test_rotations();
    in_item_t corner_pixels [8];
    int k;
    corner_pixels[0] = {8'd15, 8'd128, 8'd128};
    corner_pixels[1] = {8'd16, 8'd0, 8'd255};
    corner_pixels[2] = {8'd17, 8'd255, 8'd0};
    corner_pixels[3] = {8'd255, 8'd127, 8'd128};
    corner_pixels[4] = {8'd235, 8'd128, 8'd127};
    corner_pixels[5] = {8'd0, 8'd255, 8'd255};
    corner_pixels[6] = {8'd128, 8'd0, 8'd0};
    corner_pixels[7] = {8'd255, 8'd0, 8'd255};
    k = 0;
    for (int m = 0; m < 4; m++) begin
      apply_setup(rot_mode_e'(m), 13'd2, 13'd2, 13'd3);
      repeat (4) begin
        send_pixel(corner_pixels[k % 8]);
        k++;
      end
    end
  endtask

  task automatic test_oversize_frame();
    apply_setup(ROT_270, 13'd5000, 13'd8191, 13'd8191);
    send_pixel({8'd200, 8'd60, 8'd190});
  endtask

  task automatic test_shrink_mid_frame();
    apply_setup(ROT_0, 13'd4, 13'd2, 13'd4);
    repeat (6) send_pixel({random_sample(), random_sample(), random_sample()});
    apply_setup(ROT_180, 13'd0, 13'd0, 13'd7);
    repeat (2) send_pixel({random_sample(), random_sample(), random_sample()});
  endtask

  task automatic test_random_frames();
    int n;
    while (random_sent < 460) begin
      gaps_on = ($urandom_range(3) != 0);
      stalls_on = ($urandom_range(3) != 0);
      apply_setup(rot_mode_e'($urandom_range(3)), pick_dim(), pick_dim(), pick_stride());
      n = $urandom_range(48, 4);
      repeat (n) send_pixel({random_sample(), random_sample(), random_sample()});
      random_sent += n;
    end
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    apply_setup(ROT_90, 13'd5, 13'd3, 13'd9);
    repeat (60) send_pixel({random_sample(), random_sample(), random_sample()});
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_rotations();
    test_oversize_frame();
    test_shrink_mid_frame();
    test_random_frames();
    test_steady_stream();
    hold_input();
    wait_for_drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d pixels under %0d register setups: all rotations, clamped sizes,",
             pixels_sent, setups_applied);
    $display("mid-frame resizing and index wrap; %0d results compared, %0d errors.",
             pixels_checked, error_count);
    if (error_count == 0) begin
      $display("yuv_to_rgbx_rotating_writer_core verification clean");
    end else begin
      $display("yuv_to_rgbx_rotating_writer_core verification failed");
    end
    $finish;
  end

endmodule
